### rtl/lcs_pkg.sv
// ----------------------------------------------------------------------------
// lcs_pkg: shared types and constants for the two-point load-cell scale
// Item formats, the job passed from the front end to the divider back end,
// the calibration arming codes and the back-end state encoding.
// ----------------------------------------------------------------------------
package lcs_pkg;

    localparam int IN_SAMPLE_W  = 24;
    localparam int CAL_W        = 17;
    localparam int OUT_W        = 32;
    localparam int SAMPLE_W_MAX = 32;
    localparam int DIFF_W       = SAMPLE_W_MAX + 1;
    localparam int PROD_W       = DIFF_W + CAL_W;
    localparam int NUM_W        = PROD_W + 4;
    localparam int CNT_W        = $clog2(NUM_W);
    localparam int QUEUE_DEPTH  = 2;

    localparam int ZERO_POINT_RST = -137312;
    localparam int SPAN_POINT_RST = 3793638;
    localparam logic [CAL_W-1:0] SPAN_WEIGHT_RST = CAL_W'(4394);

    localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    typedef enum logic {
        KIND_SAMPLE = 1'b0,
        KIND_CAL    = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        ARM_NONE = 2'd0,
        ARM_ZERO = 2'd1,
        ARM_SPAN = 2'd2
    } t_arm;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MUL,
        BK_SCALE,
        BK_PREP,
        BK_DIV,
        BK_RESULT
    } t_back_state;

    typedef struct packed {
        t_kind                          kind;
        logic signed [IN_SAMPLE_W-1:0]  sample;
        logic [CAL_W-1:0]               cal_value;
    } t_in_item;

    typedef struct packed {
        logic signed [OUT_W-1:0]        weight_tenths;
        logic                           span_invalid;
        logic signed [IN_SAMPLE_W-1:0]  sample_echo;
    } t_out_item;

    // One conversion to be carried out by the back end.
    typedef struct packed {
        logic signed [DIFF_W-1:0]       diff;
        logic signed [DIFF_W-1:0]       span;
        logic [CAL_W-1:0]               weight;
        logic signed [IN_SAMPLE_W-1:0]  echo;
    } t_job;

endpackage

### rtl/lcs_front.sv
// ----------------------------------------------------------------------------
// lcs_front: request intake and calibration state
// Applies calibration commands, performs armed captures and turns each load
// sample into a conversion job for the queue.
// ----------------------------------------------------------------------------
module lcs_front #(
    parameter int SAMPLE_WIDTH = 24
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  lcs_pkg::t_in_item i_item,
    output logic              o_push_valid,
    input  logic              i_push_ready,
    output lcs_pkg::t_job     o_push_job
);

    localparam logic signed [SAMPLE_WIDTH-1:0] ZERO_RST =
        SAMPLE_WIDTH'(lcs_pkg::ZERO_POINT_RST);
    localparam logic signed [SAMPLE_WIDTH-1:0] SPAN_RST =
        SAMPLE_WIDTH'(lcs_pkg::SPAN_POINT_RST);

    logic signed [SAMPLE_WIDTH-1:0]   r_zero, n_zero;
    logic signed [SAMPLE_WIDTH-1:0]   r_span, n_span;
    logic [lcs_pkg::CAL_W-1:0]        r_weight, n_weight;
    logic [lcs_pkg::CAL_W-1:0]        r_armed_weight, n_armed_weight;
    lcs_pkg::t_arm                    r_armed, n_armed;

    logic [lcs_pkg::SAMPLE_W_MAX-1:0] w_wide;
    logic signed [SAMPLE_WIDTH-1:0]   w_raw;
    logic signed [lcs_pkg::DIFF_W-1:0] w_raw_x;
    logic signed [SAMPLE_WIDTH-1:0]   w_zero_eff;
    logic signed [SAMPLE_WIDTH-1:0]   w_span_eff;
    logic [lcs_pkg::CAL_W-1:0]        w_weight_eff;
    logic                             w_accept;

    assign o_ready  = i_push_ready;
    assign w_accept = i_valid && i_push_ready;

    assign w_wide  = lcs_pkg::SAMPLE_W_MAX'($unsigned(i_item.sample));
    assign w_raw   = w_wide[SAMPLE_WIDTH-1:0];
    assign w_raw_x = lcs_pkg::DIFF_W'(w_raw);

    // An armed capture takes effect on the very sample that completes it.
    assign w_zero_eff   = (r_armed == lcs_pkg::ARM_ZERO) ? w_raw : r_zero;
    assign w_span_eff   = (r_armed == lcs_pkg::ARM_SPAN) ? w_raw : r_span;
    assign w_weight_eff = (r_armed == lcs_pkg::ARM_SPAN) ? r_armed_weight : r_weight;

    assign o_push_valid       = i_valid && (i_item.kind == lcs_pkg::KIND_SAMPLE);
    assign o_push_job.diff    = lcs_pkg::DIFF_W'(w_raw) - lcs_pkg::DIFF_W'(w_zero_eff);
    assign o_push_job.span    = lcs_pkg::DIFF_W'(w_span_eff) - lcs_pkg::DIFF_W'(w_zero_eff);
    assign o_push_job.weight  = w_weight_eff;
    assign o_push_job.echo    = w_raw_x[lcs_pkg::IN_SAMPLE_W-1:0];

    always_comb begin
        n_zero         = r_zero;
        n_span         = r_span;
        n_weight       = r_weight;
        n_armed_weight = r_armed_weight;
        n_armed        = r_armed;
        if (w_accept) begin
            if (i_item.kind == lcs_pkg::KIND_CAL) begin
                if (i_item.cal_value == '0) begin
                    n_armed = lcs_pkg::ARM_ZERO;
                end else begin
                    n_armed        = lcs_pkg::ARM_SPAN;
                    n_armed_weight = i_item.cal_value;
                end
            end else begin
                n_zero   = w_zero_eff;
                n_span   = w_span_eff;
                n_weight = w_weight_eff;
                n_armed  = lcs_pkg::ARM_NONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero         <= ZERO_RST;
            r_span         <= SPAN_RST;
            r_weight       <= lcs_pkg::SPAN_WEIGHT_RST;
            r_armed_weight <= '0;
            r_armed        <= lcs_pkg::ARM_NONE;
        end else begin
            r_zero         <= n_zero;
            r_span         <= n_span;
            r_weight       <= n_weight;
            r_armed_weight <= n_armed_weight;
            r_armed        <= n_armed;
        end
    end

`ifndef SYNTHESIS
    a_sample_disarms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_item.kind == lcs_pkg::KIND_SAMPLE) |=> (r_armed == lcs_pkg::ARM_NONE))
        else $error("capture still armed after a sample");
`endif

endmodule

### rtl/lcs_queue.sv
// ----------------------------------------------------------------------------
// lcs_queue: job queue between front end and back end
// A short first-in first-out buffer of conversion jobs.
// ----------------------------------------------------------------------------
module lcs_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push_valid,
    output logic          o_push_ready,
    input  lcs_pkg::t_job i_push_job,
    output logic          o_pop_valid,
    input  logic          i_pop_ready,
    output lcs_pkg::t_job o_pop_job
);

    localparam int DEPTH = lcs_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    lcs_pkg::t_job    r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             w_push, w_pop;

    assign o_push_ready = (r_count != CNT_W'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_job    = r_mem[r_rd_ptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

`ifndef SYNTHESIS
    a_count_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue fill count lost a push");
`endif

endmodule

### rtl/lcs_back.sv
// ----------------------------------------------------------------------------
// lcs_back: scaling and division back end
// Multiplies the offset by the span weight and by ten, divides by the span
// with a one-bit-per-cycle restoring divider, saturates and holds the result.
// ----------------------------------------------------------------------------
module lcs_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_pop_valid,
    output logic               o_pop_ready,
    input  lcs_pkg::t_job      i_pop_job,
    output logic               o_valid,
    input  logic               i_ready,
    output lcs_pkg::t_out_item o_item
);

    localparam int DIFF_W = lcs_pkg::DIFF_W;
    localparam int PROD_W = lcs_pkg::PROD_W;
    localparam int NUM_W  = lcs_pkg::NUM_W;
    localparam int CNT_W  = lcs_pkg::CNT_W;
    localparam int OUT_W  = lcs_pkg::OUT_W;

    lcs_pkg::t_back_state        r_state, n_state;
    lcs_pkg::t_job               r_job, n_job;
    logic signed [PROD_W-1:0]    r_prod, n_prod;
    logic signed [NUM_W-1:0]     r_num, n_num;
    logic [NUM_W-1:0]            r_quo, n_quo;
    logic [DIFF_W-1:0]           r_rem, n_rem;
    logic [DIFF_W-1:0]           r_div, n_div;
    logic                        r_neg, n_neg;
    logic                        r_invalid, n_invalid;
    logic [CNT_W-1:0]            r_count, n_count;
    logic                        r_out_valid, n_out_valid;
    lcs_pkg::t_out_item          r_out, n_out;

    logic signed [lcs_pkg::CAL_W:0] w_weight_s;
    logic [DIFF_W:0]             w_shift;
    logic                        w_ge;
    logic                        w_out_free;
    logic signed [OUT_W-1:0]     w_weight_out;

    assign w_weight_s = $signed({1'b0, r_job.weight});
    assign w_shift    = {r_rem, r_quo[NUM_W-1]};
    assign w_ge       = (w_shift >= {1'b0, r_div});
    assign w_out_free = !r_out_valid || i_ready;

    assign o_pop_ready = (r_state == lcs_pkg::BK_IDLE);
    assign o_valid     = r_out_valid;
    assign o_item      = r_out;

    // Saturate the quotient magnitude with its sign applied; a zero span gives 0.
    always_comb begin
        if (r_invalid) begin
            w_weight_out = '0;
        end else if (r_neg) begin
            if (r_quo > {{(NUM_W-OUT_W){1'b0}}, lcs_pkg::OUT_MIN}) begin
                w_weight_out = lcs_pkg::OUT_MIN;
            end else begin
                w_weight_out = -$signed(r_quo[OUT_W-1:0]);
            end
        end else begin
            if (r_quo > NUM_W'(lcs_pkg::OUT_MAX)) begin
                w_weight_out = lcs_pkg::OUT_MAX;
            end else begin
                w_weight_out = $signed(r_quo[OUT_W-1:0]);
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_job       = r_job;
        n_prod      = r_prod;
        n_num       = r_num;
        n_quo       = r_quo;
        n_rem       = r_rem;
        n_div       = r_div;
        n_neg       = r_neg;
        n_invalid   = r_invalid;
        n_count     = r_count;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_ready;
        case (r_state)
            lcs_pkg::BK_IDLE: begin
                if (i_pop_valid) begin
                    n_job   = i_pop_job;
                    n_state = lcs_pkg::BK_MUL;
                end
            end
            lcs_pkg::BK_MUL: begin
                n_prod  = r_job.diff * w_weight_s;
                n_state = lcs_pkg::BK_SCALE;
            end
            lcs_pkg::BK_SCALE: begin
                n_num   = (NUM_W'(r_prod) <<< 3) + (NUM_W'(r_prod) <<< 1);
                n_state = lcs_pkg::BK_PREP;
            end
            lcs_pkg::BK_PREP: begin
                n_neg     = r_num[NUM_W-1] ^ r_job.span[DIFF_W-1];
                n_quo     = r_num[NUM_W-1] ? NUM_W'(-r_num) : NUM_W'(r_num);
                n_div     = r_job.span[DIFF_W-1] ? DIFF_W'(-r_job.span) : DIFF_W'(r_job.span);
                n_rem     = '0;
                n_count   = '0;
                n_invalid = (r_job.span == '0);
                n_state   = (r_job.span == '0) ? lcs_pkg::BK_RESULT : lcs_pkg::BK_DIV;
            end
            lcs_pkg::BK_DIV: begin
                n_rem   = w_ge ? DIFF_W'(w_shift - {1'b0, r_div}) : w_shift[DIFF_W-1:0];
                n_quo   = {r_quo[NUM_W-2:0], w_ge};
                n_count = r_count + 1'b1;
                if (r_count == CNT_W'(NUM_W - 1)) begin
                    n_state = lcs_pkg::BK_RESULT;
                end
            end
            lcs_pkg::BK_RESULT: begin
                if (w_out_free) begin
                    n_out.weight_tenths = w_weight_out;
                    n_out.span_invalid  = r_invalid;
                    n_out.sample_echo   = r_job.echo;
                    n_out_valid         = 1'b1;
                    n_state             = lcs_pkg::BK_IDLE;
                end
            end
            default: begin
                n_state = lcs_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_job     <= n_job;
        r_prod    <= n_prod;
        r_num     <= n_num;
        r_quo     <= n_quo;
        r_rem     <= n_rem;
        r_div     <= n_div;
        r_neg     <= n_neg;
        r_invalid <= n_invalid;
        r_count   <= n_count;
        r_out     <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lcs_pkg::BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

`ifndef SYNTHESIS
    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lcs_pkg::BK_DIV) |-> (r_count < CNT_W'(NUM_W)))
        else $error("divider step count out of range");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.span_invalid) |-> (r_out.weight_tenths == '0))
        else $error("zero span result carries a nonzero weight");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lcs_pkg::BK_RESULT && !w_out_free) |=> (r_state == lcs_pkg::BK_RESULT))
        else $error("result dropped while output register busy");
`endif

endmodule

### rtl/load_cell_two_point_scale.sv
// ----------------------------------------------------------------------------
// load_cell_two_point_scale: two-point calibrated load-cell converter
// Turns raw converter counts into weight in tenths of a pound.
// ----------------------------------------------------------------------------
// Each load-sample request yields one result: (sample - zero point) * span
// weight * 10 / (span point - zero point), truncated toward zero and saturated
// to 32-bit signed, or 0 with span_invalid set when the two points coincide.
// A calibration request yields no result; a value of 0 arms capture of the
// next sample as the zero point, any other value arms capture of the next
// sample as the span point at that weight in pounds, and the last command
// before a sample wins. A calibration request is handled by the front end
// alone. A sample is taken and queued; the back end then takes it from the
// queue, multiplies it by the span weight, scales it by ten, forms the
// magnitudes, runs the one-bit-per-cycle restoring divider and loads the
// output register, waiting while that register still holds an untaken
// result. The back end works on one sample at a time and takes the next from
// the queue only once the last result is loaded. A zero span skips the
// divider. A two-entry queue and the output register let the front end keep
// taking requests while the back end works or while a finished result waits
// to be taken; once two samples are waiting in the queue the input stalls,
// calibration requests included, until the back end takes the next one.
// SAMPLE_WIDTH (16 to 32) sets how many low bits of the sample are used as the
// signed count and the width of the stored calibration points.
// ----------------------------------------------------------------------------
module load_cell_two_point_scale #(
    parameter int SAMPLE_WIDTH = 24
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  lcs_pkg::t_in_item  i_item,
    output logic               o_valid,
    input  logic               i_ready,
    output lcs_pkg::t_out_item o_item
);

    // Jobs leaving the front end.
    logic          w_push_valid;
    logic          w_push_ready;
    lcs_pkg::t_job w_push_job;

    // Jobs entering the back end.
    logic          w_pop_valid;
    logic          w_pop_ready;
    lcs_pkg::t_job w_pop_job;

    // The front end holds all calibration state, so captures happen in
    // request order regardless of how far behind the back end is.
    lcs_front #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_item       (i_item),
        .o_push_valid (w_push_valid),
        .i_push_ready (w_push_ready),
        .o_push_job   (w_push_job)
    );

    lcs_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .o_push_ready (w_push_ready),
        .i_push_job   (w_push_job),
        .o_pop_valid  (w_pop_valid),
        .i_pop_ready  (w_pop_ready),
        .o_pop_job    (w_pop_job)
    );

    // The back end carries out the scaling and division and owns the output register.
    lcs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (w_pop_valid),
        .o_pop_ready (w_pop_ready),
        .i_pop_job   (w_pop_job),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_item      (o_item)
    );

endmodule

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking testbench for the two-point load-cell scale
// Drives load-sample and calibration requests through the valid/ready input
// channel and checks every result against a cycle-free weight predictor kept
// alongside the stimulus. A directed table exercises reset calibration, the
// sample extremes, overriding commands, zero span and saturation. Random
// traffic follows, under three sender/receiver idling mixes.
// ----------------------------------------------------------------------------
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import lcs_pkg::*;

    localparam int RESET_CYCLES    = 9;
    localparam int STALL_LIMIT     = 5000;
    localparam int DRAIN_CYCLES    = 100;
    localparam int RANDOM_REQUESTS = 1850;
    localparam int MAX_REPORTS     = 10;
    localparam int MAX_GAP         = 40;

    // Calibration in force after reset.
    localparam longint ZERO_AT_RESET   = -137312;
    localparam longint SPAN_AT_RESET   = 3793638;
    localparam int     WEIGHT_AT_RESET = 4394;

    localparam longint COUNT_MAX  = 8388607;
    localparam longint COUNT_MIN  = -8388608;
    localparam int     TENTHS_MAX = 2147483647;
    localparam int     TENTHS_MIN = -2147483647 - 1;

    logic       i_clk   = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_ready;
    t_in_item   i_item  = '0;
    logic       o_valid;
    logic       i_ready = 1'b0;
    t_out_item  o_item;

    // Idling mix, in cycles out of a hundred.
    int send_idle_pct = 12;
    int recv_idle_pct = 73;

    // Predictor copy of the calibration state.
    longint          cal_zero;
    longint          cal_span;
    logic [CAL_W-1:0] cal_weight;
    logic [CAL_W-1:0] pending_weight;
    t_arm            pending_arm;

    // Weights still owed by the block, oldest first.
    t_out_item expected_weights[$];
    t_out_item oldest;

    int requests_sent   = 0;
    int cal_requests    = 0;
    int results_checked = 0;
    int invalid_results = 0;
    int mismatches      = 0;
    int idle_cycles     = 0;

    // One row of the directed table. Where answer_given is set, the weight and
    // flag typed here are what the block must produce; otherwise the
    // predictor supplies the answer.
    typedef struct {
        t_kind kind;
        int    sample_raw;
        int    cal_lbs;
        bit    answer_given;
        int    answer_tenths;
        bit    answer_invalid;
    } t_directed_row;

    localparam int DIRECTED_ROWS = 24;

    t_directed_row directed_table [DIRECTED_ROWS] = '{
        // Reset calibration: the reset zero point reads 0, the reset span
        // point reads the reset span weight.
        '{KIND_SAMPLE, -137312,       0,      1, 0,          0},
        '{KIND_SAMPLE, 3793638,       0,      1, 43940,      0},
        '{KIND_SAMPLE, 8388607,       0,      0, 0,          0},
        '{KIND_SAMPLE, -8388608,      0,      0, 0,          0},
        // Two commands in a row: the later span command wins.
        '{KIND_CAL,    0,             0,      0, 0,          0},
        '{KIND_CAL,    0,             99999,  0, 0,          0},
        '{KIND_SAMPLE, 1000,          0,      1, 999990,     0},
        // Largest weight overridden by a zero command; the new zero then
        // coincides with the span point.
        '{KIND_CAL,    0,             131071, 0, 0,          0},
        '{KIND_CAL,    0,             0,      0, 0,          0},
        '{KIND_SAMPLE, 1000,          0,      1, 0,          1},
        '{KIND_SAMPLE, -8388608,      0,      1, 0,          1},
        // Span at the most negative count, weight of one pound.
        '{KIND_CAL,    0,             1,      0, 0,          0},
        '{KIND_SAMPLE, -8388608,      0,      1, 10,         0},
        '{KIND_SAMPLE, 8388607,       0,      0, 0,          0},
        // Zero at the most positive count: the widest possible span.
        '{KIND_CAL,    0,             0,      0, 0,          0},
        '{KIND_SAMPLE, 8388607,       0,      1, 0,          0},
        '{KIND_SAMPLE, -8388608,      0,      1, 10,         0},
        // A one-count span at the largest weight drives both saturations.
        '{KIND_CAL,    0,             0,      0, 0,          0},
        '{KIND_SAMPLE, 0,             0,      1, 0,          0},
        '{KIND_CAL,    0,             131071, 0, 0,          0},
        '{KIND_SAMPLE, 1,             0,      1, 1310710,    0},
        '{KIND_SAMPLE, 8388607,       0,      1, TENTHS_MAX, 0},
        '{KIND_SAMPLE, -8388608,      0,      1, TENTHS_MIN, 0},
        '{KIND_SAMPLE, -1,            0,      1, -1310710,   0}
    };

    load_cell_two_point_scale u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_item  (o_item)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Wraps a count to the sample width, as the block's stored points are.
    function automatic longint wrap_count(input longint value);
        logic signed [IN_SAMPLE_W-1:0] narrow;
        narrow = value[IN_SAMPLE_W-1:0];
        return narrow;
    endfunction

    function automatic void reset_calibration();
        cal_zero       = wrap_count(ZERO_AT_RESET);
        cal_span       = wrap_count(SPAN_AT_RESET);
        cal_weight     = CAL_W'(WEIGHT_AT_RESET);
        pending_arm    = ARM_NONE;
        pending_weight = '0;
    endfunction

    // Applies one request to the predictor state. Returns 1 and the expected
    // result for a load sample, 0 for a calibration command.
    function automatic bit predict_weight(input t_in_item req, output t_out_item res);
        longint raw;
        longint span;
        longint num;
        longint quot;
        res = '0;
        if (req.kind == KIND_CAL) begin
            if (req.cal_value == '0) begin
                pending_arm = ARM_ZERO;
            end else begin
                pending_weight = req.cal_value;
                pending_arm    = ARM_SPAN;
            end
            return 1'b0;
        end
        raw = req.sample;
        case (pending_arm)
            ARM_ZERO: begin
                cal_zero = raw;
            end
            ARM_SPAN: begin
                cal_span   = raw;
                cal_weight = pending_weight;
            end
            default: begin
            end
        endcase
        pending_arm     = ARM_NONE;
        span            = cal_span - cal_zero;
        res.sample_echo = req.sample;
        if (span == 0) begin
            res.span_invalid = 1'b1;
        end else begin
            num  = (raw - cal_zero) * longint'(cal_weight) * 10;
            quot = num / span;
            if (quot > longint'(TENTHS_MAX)) begin
                quot = TENTHS_MAX;
            end
            if (quot < longint'(TENTHS_MIN)) begin
                quot = TENTHS_MIN;
            end
            res.weight_tenths = quot[OUT_W-1:0];
        end
        return 1'b1;
    endfunction

    // Random request. Calibration commands are sprinkled in so that captures
    // land on random samples; samples cluster around the current points so
    // that zero spans and small weights turn up as well as wide sweeps.
    function automatic t_in_item random_request();
        t_in_item    req;
        logic [31:0] bits;
        longint      count;
        int          pick;
        bits          = $urandom;
        req.sample    = bits[IN_SAMPLE_W-1:0];
        bits          = $urandom;
        req.cal_value = bits[CAL_W-1:0];
        pick          = $urandom_range(99);
        if (pick < 6) begin
            req.kind      = KIND_CAL;
            req.cal_value = '0;
        end else if (pick < 12) begin
            req.kind = KIND_CAL;
            if ($urandom_range(9) != 0) begin
                req.cal_value = CAL_W'($urandom_range(99999, 1));
            end
        end else begin
            req.kind = KIND_SAMPLE;
            count    = req.sample;
            case ($urandom_range(9))
                3, 4:    count = cal_zero + longint'($urandom_range(2000)) - 1000;
                5, 6:    count = cal_span + longint'($urandom_range(2000)) - 1000;
                7:       count = cal_zero;
                8:       count = cal_span;
                9:       count = $urandom_range(1) ? COUNT_MAX : COUNT_MIN;
                default: begin
                end
            endcase
            req.sample = count[IN_SAMPLE_W-1:0];
        end
        return req;
    endfunction

    // Offers one request after a random gap and waits for it to be taken.
    // The predictor only sees the request once the handshake has happened.
    task automatic send_request(input t_in_item req, input bit answer_given,
                                input t_out_item answer);
        int        gap;
        bit        has_result;
        t_out_item predicted;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) begin
            gap++;
        end
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= req;
        do @(posedge i_clk); while (!o_ready);
        has_result = predict_weight(req, predicted);
        if (has_result) begin
            expected_weights.push_back(answer_given ? answer : predicted);
        end else begin
            cal_requests++;
        end
        requests_sent++;
    endtask

    // Holds the sender off until every owed result has been taken. The task
    // always waits on the clock before checking, so that valid is not lowered
    // and raised again in the same step.
    task automatic wait_for_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_weights.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // The receiver decides afresh on every cycle whether to take a result.
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Result checker: every result taken is compared, field by field, with
    // the oldest outstanding expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            results_checked++;
            if (o_item.span_invalid === 1'b1) begin
                invalid_results++;
            end
            if (expected_weights.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("Unexpected result: weight %0d invalid %0b echo %0d",
                             o_item.weight_tenths, o_item.span_invalid,
                             o_item.sample_echo);
                end
            end else begin
                oldest = expected_weights.pop_front();
                if (o_item.weight_tenths !== oldest.weight_tenths ||
                    o_item.span_invalid  !== oldest.span_invalid  ||
                    o_item.sample_echo   !== oldest.sample_echo) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("Mismatch on result %0d: weight %0d/%0d invalid %0b/%0b echo %0d/%0d (expected/actual)",
                                 results_checked,
                                 oldest.weight_tenths, o_item.weight_tenths,
                                 oldest.span_invalid, o_item.span_invalid,
                                 oldest.sample_echo, o_item.sample_echo);
                    end
                end
            end
        end
    end

    // Watchdog: ends the run if no request moves on either channel for too
    // long, which is how a lost or stuck result shows itself.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Watchdog: no request moved for %0d cycles, %0d results outstanding",
                     idle_cycles, expected_weights.size());
            $display("FAILED: results differ");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        t_in_item  req;
        t_out_item answer;
        reset_calibration();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int phase = 0; phase < 3; phase++) begin
            // First the sender rarely idles and the receiver mostly stalls,
            // then the other way round, and at last both run flat out.
            case (phase)
                0: begin
                    send_idle_pct = 12;
                    recv_idle_pct = 73;
                end
                1: begin
                    send_idle_pct = 73;
                    recv_idle_pct = 12;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase

            if (phase == 0) begin
                for (int row = 0; row < DIRECTED_ROWS; row++) begin
                    req                  = '0;
                    req.kind             = directed_table[row].kind;
                    req.sample           = directed_table[row].sample_raw[IN_SAMPLE_W-1:0];
                    req.cal_value        = directed_table[row].cal_lbs[CAL_W-1:0];
                    answer.weight_tenths = directed_table[row].answer_tenths;
                    answer.span_invalid  = directed_table[row].answer_invalid;
                    answer.sample_echo   = req.sample;
                    send_request(req, directed_table[row].answer_given, answer);
                end
                // Let the directed results drain before random traffic starts.
                wait_for_results();
            end

            for (int n = 0; n < RANDOM_REQUESTS / 3; n++) begin
                send_request(random_request(), 1'b0, '0);
            end
            wait_for_results();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d requests, %0d of them calibration commands.",
                 requests_sent, cal_requests);
        $display("Checked %0d results, %0d with a zero span; %0d mismatches.",
                 results_checked, invalid_results, mismatches);
        if (mismatches == 0 && expected_weights.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/lcs_pkg.sv
rtl/lcs_front.sv
rtl/lcs_queue.sv
rtl/lcs_back.sv
rtl/load_cell_two_point_scale.sv
tb/sv/tb.sv
